// File: hw/rtl/mbd_pkg.sv
// Shared types and constants for the mask box downsampler.
// Used by mbd_ctrl, mbd_dp, mbd_chk and the top level mask_box_downsample.
`default_nettype none

package mbd_pkg;

	// Default sizing of the tile-sum memory and the largest tile edge
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_BLOCK_DEF = 64;
	localparam int HEIGHT_LIMIT  = 4096;

	// Field widths
	localparam int SAMPLE_W  = 16;
	localparam int VALUE_W   = 8;
	localparam int POS_W     = 12;
	localparam int DIM_W     = 13;
	localparam int BLK_REG_W = 7;
	localparam int SUM_W     = 28;

	// Scaling: byte full scale, and the width of sum * 255
	localparam int BYTE_SCALE = 255;
	localparam int NUM_W      = SUM_W + 8;

	// Restoring divider: one saturation check, then eight quotient bits
	localparam int DIV_STEPS = 9;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// APB register file
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BLOCK_SIZE  = 2'd2;

	localparam logic [DIM_W-1:0]     GRID_WIDTH_RST  = 13'd256;
	localparam logic [DIM_W-1:0]     GRID_HEIGHT_RST = 13'd256;
	localparam logic [BLK_REG_W-1:0] BLOCK_SIZE_RST  = 7'd4;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic restart;   // clear frame position
		logic accept;    // take a sample, read its tile sum, advance position
		logic scale;     // sample times column weight
		logic weight;    // times row weight
		logic acc;       // update tile sum and write it back
		logic div_load;  // load numerator and shifted divisor
		logic div_step;  // one divider step
		logic div_first; // first step is the saturation check
		logic out_load;  // move the finished byte into the output register
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic emit;      // current request completes its tile
	} dp_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/mbd_ctrl.sv
// Controller for the mask box downsampler: sequences one request at a time
// through multiply, accumulate and, for a completed tile, divide, and owns the output valid.
// Depends on mbd_pkg.
`default_nettype none

module mbd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	input  wire logic             cfg_restart,
	input  wire mbd_pkg::dp_sts_t sts,
	output mbd_pkg::dp_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_ACC,
		ST_LOAD,
		ST_DIV,
		ST_POST
	} state_t;

	state_t                         state_q;
	logic [mbd_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                           out_valid_q;
	logic                           accept;
	logic                           out_free;

	// Handshake decode
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Datapath commands
	always_comb begin
		cmd           = '0;
		cmd.restart   = cfg_restart;
		cmd.accept    = accept;
		cmd.scale     = (state_q == ST_MUL);
		cmd.weight    = (state_q == ST_SCALE);
		cmd.acc       = (state_q == ST_ACC);
		cmd.div_load  = (state_q == ST_LOAD);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.div_first = (state_q == ST_DIV) &&
			(cnt_q == mbd_pkg::DIV_CNT_W'(mbd_pkg::DIV_STEPS - 1));
		cmd.out_load  = (state_q == ST_POST) && out_free;
	end

	// State, step count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_MUL;
				end
				ST_MUL:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_ACC;
				ST_ACC: begin
					state_q <= sts.emit ? ST_LOAD : ST_IDLE;
				end
				ST_LOAD: begin
					cnt_q   <= mbd_pkg::DIV_CNT_W'(mbd_pkg::DIV_STEPS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_POST;
				end
				ST_POST: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			// Hold the result until taken
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mbd_dp.sv
// Datapath for the mask box downsampler: frame position counters, edge
// weights, tile-sum memory, multiply-accumulate and a restoring divider.
// Depends on mbd_pkg; driven by mbd_ctrl commands.
`default_nettype none

module mbd_dp #(
	parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_BLOCK = mbd_pkg::MAX_BLOCK_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [mbd_pkg::DIM_W-1:0]       grid_width,
	input  wire logic [mbd_pkg::DIM_W-1:0]       grid_height,
	input  wire logic [mbd_pkg::BLK_REG_W-1:0]   block_size,
	input  wire logic [mbd_pkg::SAMPLE_W-1:0]    sample,
	input  wire mbd_pkg::dp_cmd_t                cmd,
	output mbd_pkg::dp_sts_t                     sts,
	output logic [mbd_pkg::VALUE_W-1:0]          mask_value,
	output logic [mbd_pkg::POS_W-1:0]            block_x,
	output logic [mbd_pkg::POS_W-1:0]            block_z,
	output logic                                 last
);

	localparam int DW_MAX = (1 << mbd_pkg::DIM_W) - 1;
	localparam int WCAP   = (MAX_WIDTH < DW_MAX) ? MAX_WIDTH : DW_MAX;
	localparam int BR_MAX = (1 << mbd_pkg::BLK_REG_W) - 1;
	localparam int BCAP   = (MAX_BLOCK < BR_MAX) ? MAX_BLOCK : BR_MAX;
	localparam int BW     = $clog2(BCAP + 1);
	localparam int TW     = $clog2(MAX_WIDTH);
	localparam int P1W    = mbd_pkg::SAMPLE_W + BW;
	localparam int P2W    = mbd_pkg::SAMPLE_W + 2 * BW;
	localparam int DENW   = 2 * BW + 16;
	localparam int CW     = (mbd_pkg::NUM_W > DENW + 8) ? mbd_pkg::NUM_W : DENW + 8;
	localparam int PW     = mbd_pkg::POS_W;
	localparam int DIMW   = mbd_pkg::DIM_W;

	// Effective dimensions, out-of-range values pulled into range
	logic [DIMW-1:0] w_eff;
	logic [DIMW-1:0] h_eff;
	logic [BW-1:0]   b_eff;

	always_comb begin
		if (grid_width == '0)               w_eff = DIMW'(1);
		else if (grid_width > DIMW'(WCAP))  w_eff = DIMW'(WCAP);
		else                                w_eff = grid_width;

		if (grid_height == '0)                             h_eff = DIMW'(1);
		else if (grid_height > DIMW'(mbd_pkg::HEIGHT_LIMIT)) h_eff = DIMW'(mbd_pkg::HEIGHT_LIMIT);
		else                                               h_eff = grid_height;

		if (block_size == '0)                            b_eff = BW'(1);
		else if (block_size > mbd_pkg::BLK_REG_W'(BCAP)) b_eff = BW'(BCAP);
		else                                             b_eff = BW'(block_size);
	end

	// Frame position: sample position, offset in tile, tile index, tile origin
	logic [PW-1:0] x_q, z_q;
	logic [BW-1:0] ox_q, oz_q;
	logic [PW-1:0] bx_q, bz_q;
	logic [PW-1:0] basex_q, basez_q;

	logic            last_col, last_row, done_x, done_z, tile_first;
	logic [13:0]     spanx, spanz;
	logic [BW-1:0]   wx, wz;
	logic [DIMW-1:0] x_inc, z_inc;

	// Edge weights and tile completion for the current position
	always_comb begin
		last_col   = (DIMW'(x_q) == w_eff - DIMW'(1));
		last_row   = (DIMW'(z_q) == h_eff - DIMW'(1));
		done_x     = (ox_q == b_eff - BW'(1)) || last_col;
		done_z     = (oz_q == b_eff - BW'(1)) || last_row;
		tile_first = (ox_q == '0) && (oz_q == '0);
		spanx      = 14'(basex_q) + 14'(b_eff) - 14'(w_eff);
		spanz      = 14'(basez_q) + 14'(b_eff) - 14'(h_eff);
		wx         = last_col ? BW'(spanx) + BW'(1) : BW'(1);
		wz         = last_row ? BW'(spanz) + BW'(1) : BW'(1);
		x_inc      = DIMW'(x_q) + DIMW'(1);
		z_inc      = DIMW'(z_q) + DIMW'(1);
	end

	// Advance position on each accepted request; restart on a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0; z_q <= '0; ox_q <= '0; oz_q <= '0;
			bx_q <= '0; bz_q <= '0; basex_q <= '0; basez_q <= '0;
		end else if (cmd.restart) begin
			x_q <= '0; z_q <= '0; ox_q <= '0; oz_q <= '0;
			bx_q <= '0; bz_q <= '0; basex_q <= '0; basez_q <= '0;
		end else if (cmd.accept) begin
			priority if (x_inc >= w_eff) begin
				x_q <= '0; ox_q <= '0; bx_q <= '0; basex_q <= '0;
				priority if (z_inc >= h_eff) begin
					z_q <= '0; oz_q <= '0; bz_q <= '0; basez_q <= '0;
				end else if (oz_q == b_eff - BW'(1)) begin
					z_q     <= z_inc[PW-1:0];
					oz_q    <= '0;
					bz_q    <= bz_q + 1'b1;
					basez_q <= basez_q + PW'(b_eff);
				end else begin
					z_q  <= z_inc[PW-1:0];
					oz_q <= oz_q + 1'b1;
				end
			end else if (x_inc[PW]) begin
				// Column counter wraps past its width: start the row's columns over
				x_q <= '0; ox_q <= '0; bx_q <= '0; basex_q <= '0;
			end else if (ox_q == b_eff - BW'(1)) begin
				x_q     <= x_inc[PW-1:0];
				ox_q    <= '0;
				bx_q    <= bx_q + 1'b1;
				basex_q <= basex_q + PW'(b_eff);
			end else begin
				x_q  <= x_inc[PW-1:0];
				ox_q <= ox_q + 1'b1;
			end
		end
	end

	// Per-request payload
	logic [mbd_pkg::SAMPLE_W-1:0] samp_q;
	logic [BW-1:0]                wx_q, wz_q;
	logic                         first_q, emit_q, last_q;
	logic [PW-1:0]                tile_x_q, tile_z_q;
	logic [TW-1:0]                waddr_q;
	logic [P1W-1:0]               prod_q;
	logic [P2W-1:0]               prod2;
	logic [mbd_pkg::SUM_W-1:0]    contrib_q, rd_q, sum, sum_q;
	logic [2*BW-1:0]              b2_q;
	logic [DENW-1:0]              den;
	logic [CW-1:0]                rem_q, dsh_q;
	logic                         ge, sat_q;
	logic [mbd_pkg::VALUE_W-1:0]  quo_q;
	logic [mbd_pkg::VALUE_W-1:0]  value_q;
	logic [PW-1:0]                out_x_q, out_z_q;
	logic                         out_last_q;

	// Tile-sum memory, one entry per tile column
	logic [mbd_pkg::SUM_W-1:0] tile_mem [MAX_WIDTH];

	assign prod2 = prod_q * wz_q;
	assign sum   = first_q ? contrib_q : rd_q + contrib_q;
	assign den   = (DENW'(b2_q) << 16) - DENW'(b2_q);
	assign ge    = (rem_q >= dsh_q);

	// Read the tile sum at accept, write it back after accumulate
	always_ff @(posedge clk) begin
		if (cmd.accept) rd_q <= tile_mem[TW'(bx_q)];
		if (cmd.acc)    tile_mem[waddr_q] <= sum;
	end

	// Multiply, accumulate, divide, output
	always_ff @(posedge clk) begin
		b2_q <= b_eff * b_eff;

		if (cmd.accept) begin
			samp_q   <= sample;
			wx_q     <= wx;
			wz_q     <= wz;
			first_q  <= tile_first;
			emit_q   <= done_x && done_z;
			last_q   <= last_col && last_row;
			tile_x_q <= bx_q;
			tile_z_q <= bz_q;
			waddr_q  <= TW'(bx_q);
		end

		if (cmd.scale)  prod_q    <= samp_q * wx_q;
		if (cmd.weight) contrib_q <= mbd_pkg::SUM_W'(prod2);
		if (cmd.acc)    sum_q     <= sum;

		// Numerator is sum * 255; divisor starts shifted up for the saturation check
		if (cmd.div_load) begin
			rem_q <= (CW'(sum_q) << 8) - CW'(sum_q);
			dsh_q <= CW'(den) << 8;
		end

		// One quotient bit per step after the saturation check
		if (cmd.div_step) begin
			dsh_q <= dsh_q >> 1;
			if (cmd.div_first) begin
				sat_q <= ge;
				quo_q <= '0;
			end else begin
				if (ge) rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[mbd_pkg::VALUE_W-2:0], ge};
			end
		end

		if (cmd.out_load) begin
			value_q    <= sat_q ? mbd_pkg::VALUE_W'(mbd_pkg::BYTE_SCALE) : quo_q;
			out_x_q    <= tile_x_q;
			out_z_q    <= tile_z_q;
			out_last_q <= last_q;
		end
	end

	assign sts.emit   = emit_q;
	assign mask_value = value_q;
	assign block_x    = out_x_q;
	assign block_z    = out_z_q;
	assign last       = out_last_q;

endmodule

`default_nettype wire

// File: hw/rtl/mask_box_downsample.sv
// Top level of the mask box downsampler: APB register file, controller
// and datapath. Depends on mbd_pkg, mbd_ctrl and mbd_dp.
//
//   port group  direction  handshake                     payload
//   in          receive    in_valid / in_stall           sample
//   out         send       out_valid / out_stall         mask_value, block_x, block_z, last
//   cfg         APB slave  psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A sample that does not complete a tile passes the multiply, scale and accumulate
// states; one that completes a tile then loads the restoring divider, which yields
// one quotient bit per cycle after a saturation check, and waits for the output.
// The tile-sum memory reads at accept and writes back in the accumulate state.
// Reset clears positions and loads registers (256, 256, 4); the memory needs no clear.
// A new sample is taken while a result waits under out_stall; a second result
// holds in the datapath until the output register frees.
`default_nettype none

module mask_box_downsample #(
	parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_BLOCK = mbd_pkg::MAX_BLOCK_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [mbd_pkg::SAMPLE_W-1:0]      sample,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [mbd_pkg::VALUE_W-1:0]            mask_value,
	output logic [mbd_pkg::POS_W-1:0]              block_x,
	output logic [mbd_pkg::POS_W-1:0]              block_z,
	output logic                                   last,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [mbd_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [mbd_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [mbd_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                   pready
);

	logic [mbd_pkg::DIM_W-1:0]     grid_width_q;
	logic [mbd_pkg::DIM_W-1:0]     grid_height_q;
	logic [mbd_pkg::BLK_REG_W-1:0] block_size_q;
	logic [1:0]                    reg_idx;
	logic                          wr_en;
	logic                          cfg_restart;
	mbd_pkg::dp_cmd_t              cmd;
	mbd_pkg::dp_sts_t              sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Any write to a defined register restarts the frame
	assign cfg_restart = wr_en && ((reg_idx == mbd_pkg::REG_GRID_WIDTH) ||
		(reg_idx == mbd_pkg::REG_GRID_HEIGHT) || (reg_idx == mbd_pkg::REG_BLOCK_SIZE));

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= mbd_pkg::GRID_WIDTH_RST;
			grid_height_q <= mbd_pkg::GRID_HEIGHT_RST;
			block_size_q  <= mbd_pkg::BLOCK_SIZE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				mbd_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[mbd_pkg::DIM_W-1:0];
				mbd_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[mbd_pkg::DIM_W-1:0];
				mbd_pkg::REG_BLOCK_SIZE:  block_size_q  <= pwdata[mbd_pkg::BLK_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (reg_idx)
			mbd_pkg::REG_GRID_WIDTH:  prdata = mbd_pkg::APB_DATA_W'(grid_width_q);
			mbd_pkg::REG_GRID_HEIGHT: prdata = mbd_pkg::APB_DATA_W'(grid_height_q);
			mbd_pkg::REG_BLOCK_SIZE:  prdata = mbd_pkg::APB_DATA_W'(block_size_q);
			default:                  prdata = '0;
		endcase
	end

	mbd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cfg_restart (cfg_restart),
		.sts         (sts),
		.cmd         (cmd)
	);

	mbd_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_BLOCK (MAX_BLOCK)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.block_size  (block_size_q),
		.sample      (sample),
		.cmd         (cmd),
		.sts         (sts),
		.mask_value  (mask_value),
		.block_x     (block_x),
		.block_z     (block_z),
		.last        (last)
	);

endmodule

`default_nettype wire

// File: hw/rtl/mbd_chk.sv
// Port-level checks for the mask box downsampler, bound to the top level.
// Depends on mbd_pkg and mask_box_downsample.
`default_nettype none

module mbd_chk (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [mbd_pkg::VALUE_W-1:0]  mask_value,
	input wire logic [mbd_pkg::POS_W-1:0]    block_x,
	input wire logic [mbd_pkg::POS_W-1:0]    block_z,
	input wire logic                         last
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mask_value) &&
		$stable(block_x) && $stable(block_z) && $stable(last))
		else $error("stalled result changed");

	// One request at a time: stall right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while busy");

	// A result never appears in the cycle after an accept
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && !in_stall))
		else $error("result too soon after accept");

	// A result only rises out of a busy cycle, never from idle
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised while idle");

endmodule

bind mask_box_downsample mbd_chk u_mbd_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.mask_value (mask_value),
	.block_x    (block_x),
	.block_z    (block_z),
	.last       (last)
);

`default_nettype wire

// File: tb/sv/tb_mask_box_downsample.sv
// Self-checking testbench for mask_box_downsample: streams masks under several
// grid and tile settings, predicts every tile byte and checks it on the output.
// Depends on mbd_pkg and the mask_box_downsample top level.
module tb_mask_box_downsample;
	timeunit 1ns;
	timeprecision 1ps;

	import mbd_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS  = 1500;

	// One predicted tile byte
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   col;
		logic [POS_W-1:0]   row;
		logic               is_last;
	} tile_byte_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [SAMPLE_W-1:0]   sample = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [VALUE_W-1:0]    mask_value;
	logic [POS_W-1:0]      block_x;
	logic [POS_W-1:0]      block_z;
	logic                  last;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Register copies and frame position of the predictor
	logic [DIM_W-1:0]     grid_w = GRID_WIDTH_RST;
	logic [DIM_W-1:0]     grid_h = GRID_HEIGHT_RST;
	logic [BLK_REG_W-1:0] tile_edge = BLOCK_SIZE_RST;
	logic [POS_W-1:0]     col_pos = '0;
	logic [POS_W-1:0]     row_pos = '0;
	logic [SUM_W-1:0]     tile_acc [MAX_WIDTH_DEF];

	logic [SAMPLE_W-1:0] pending_samples [$];
	tile_byte_t          expected_bytes [$];
	int                  errors = 0;
	int                  items_queued = 0;
	int                  send_idle_pct = 0;
	int                  stall_pct = 0;

	mask_box_downsample dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.mask_value (mask_value),
		.block_x    (block_x),
		.block_z    (block_z),
		.last       (last),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #5 clk = ~clk;

	task automatic note_failure(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("%s", msg);
		end
	endtask

	// Out-of-range register values act as the nearest legal one
	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Accumulate one sample into its tile column; report the byte if the tile completes
	function automatic tile_byte_t predict_tile_byte(input logic [SAMPLE_W-1:0] s,
			output bit produced);
		int unsigned w, h, b, x, z, bx, bz, wx, wz, contrib, tex, tez;
		longint unsigned num, den, q;
		tile_byte_t r;
		w = clamp_dim(grid_w, MAX_WIDTH_DEF);
		h = clamp_dim(grid_h, HEIGHT_LIMIT);
		b = clamp_dim(tile_edge, MAX_BLOCK_DEF);
		x = col_pos;
		z = row_pos;
		produced = 1'b0;
		r = '0;
		if (x >= w || z >= h) begin
			x = 0;
			z = 0;
		end
		bx = x / b;
		bz = z / b;
		// replicate the last column and row over the overhang
		wx = 1;
		wz = 1;
		if (x == w - 1) wx += (bx + 1) * b - w;
		if (z == h - 1) wz += (bz + 1) * b - h;
		contrib = s * wx * wz;
		if (x % b == 0 && z % b == 0) tile_acc[bx] = SUM_W'(contrib);
		else tile_acc[bx] = SUM_W'(tile_acc[bx] + contrib);
		tex = (bx + 1) * b;
		if (tex > w) tex = w;
		tez = (bz + 1) * b;
		if (tez > h) tez = h;
		if (x == tex - 1 && z == tez - 1) begin
			num = tile_acc[bx];
			num = num * BYTE_SCALE;
			den = b;
			den = den * b * 65535;
			q = num / den;
			if (q > 255) q = 255;
			r.value = VALUE_W'(q);
			r.col = POS_W'(bx);
			r.row = POS_W'(bz);
			r.is_last = (x == w - 1 && z == h - 1);
			produced = 1'b1;
		end
		// advance the raster position, wrap at end of frame
		x++;
		if (x >= w) begin
			x = 0;
			z++;
			if (z >= h) z = 0;
		end
		col_pos = POS_W'(x);
		row_pos = POS_W'(z);
		return r;
	endfunction

	// Sample driver: hold while stalled, otherwise take the next request or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				sample <= pending_samples.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Random receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Predict on every accepted request
	always @(posedge clk) begin
		tile_byte_t nxt;
		bit produced;
		if (arst_n && in_valid && !in_stall) begin
			nxt = predict_tile_byte(sample, produced);
			if (produced) expected_bytes.push_back(nxt);
		end
	end

	// Check every accepted result against the oldest expectation
	always @(posedge clk) begin
		tile_byte_t exp_b;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				note_failure($sformatf("unexpected byte value=%0d x=%0d z=%0d last=%0d",
					mask_value, block_x, block_z, last));
			end else begin
				exp_b = expected_bytes.pop_front();
				if (exp_b.value !== mask_value || exp_b.col !== block_x ||
						exp_b.row !== block_z || exp_b.is_last !== last) begin
					note_failure($sformatf(
						"mismatch: expected value=%0d x=%0d z=%0d last=%0d, got %0d %0d %0d %0d",
						exp_b.value, exp_b.col, exp_b.row, exp_b.is_last,
						mask_value, block_x, block_z, last));
				end
			end
		end
	end

	// Write a register, read it back, and restart the predicted frame
	task automatic set_register(input logic [1:0] idx, input logic [APB_DATA_W-1:0] data);
		logic [APB_DATA_W-1:0] rd, want;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite <= 1'b0;
		do @(posedge clk); while (0);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_GRID_WIDTH: begin
				grid_w = data[DIM_W-1:0];
				want = grid_w;
			end
			REG_GRID_HEIGHT: begin
				grid_h = data[DIM_W-1:0];
				want = grid_h;
			end
			default: begin
				tile_edge = data[BLK_REG_W-1:0];
				want = tile_edge;
			end
		endcase
		col_pos = '0;
		row_pos = '0;
		if (rd !== want) begin
			note_failure($sformatf("register %0d readback: expected %0d, got %0d",
				idx, want, rd));
		end
	endtask

	task automatic configure(input int w, input int h, input int b);
		set_register(REG_GRID_WIDTH, w);
		set_register(REG_GRID_HEIGHT, h);
		set_register(REG_BLOCK_SIZE, b);
	endtask

	task automatic push_sample(input logic [SAMPLE_W-1:0] s);
		pending_samples.push_back(s);
		items_queued++;
	endtask

	// Wait until every request is taken and every byte is back, then let the pipe settle
	task automatic drain();
		while (pending_samples.size() != 0 || in_valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 58;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 58;
			end
			default: begin
				send_idle_pct = 27;
				stall_pct = 27;
			end
		endcase
	endtask

	// Full scale and zero show up often so saturated and empty tiles are common
	function automatic logic [SAMPLE_W-1:0] random_sample();
		int unsigned r;
		r = $urandom_range(7);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return SAMPLE_W'($urandom_range(65535));
	endfunction

	initial begin
		int unsigned w, h, b, n, ew, eh, frame;
		int phase;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero registers act as a 1x1 grid with 1x1 tiles: every sample ends a frame
		set_idling(0);
		configure(0, 0, 0);
		push_sample(16'hFFFF);
		push_sample(16'h0000);
		push_sample(16'h8000);
		push_sample(16'h0001);
		drain();

		// overhanging tiles, a full frame, then wrap into a partial second frame
		configure(3, 2, 2);
		repeat (6) push_sample(16'hFFFF);
		push_sample(16'h1234);
		push_sample(16'hFFFF);
		drain();

		// oversized registers clamp; a mid-frame write restarts the frame
		configure(5000, 8191, 127);
		push_sample(16'hFFFF);
		push_sample(16'h7FFF);
		push_sample(16'h0000);
		push_sample(16'hFFFF);
		drain();
		set_register(REG_BLOCK_SIZE, 1);
		push_sample(16'hFFFF);
		push_sample(16'h0000);
		push_sample(16'hAAAA);
		push_sample(16'h5555);
		drain();

		// random settings, mostly small grids with one to three whole frames and part of the next
		items_queued = 0;
		phase = 0;
		while (items_queued < RANDOM_ITEMS) begin
			set_idling(phase % 4);
			case ($urandom_range(9))
				0: begin
					w = $urandom_range(4096, 8191);
					h = $urandom_range(0, 3);
					b = $urandom_range(0, 127);
					n = 200;
				end
				1: begin
					w = $urandom_range(0, 3);
					h = $urandom_range(4096, 8191);
					b = $urandom_range(32, 127);
					n = 200;
				end
				2: begin
					w = $urandom_range(1, 20);
					h = $urandom_range(1, 20);
					b = $urandom_range(64, 127);
					n = w * h + $urandom_range(0, w * h - 1);
				end
				default: begin
					w = $urandom_range(0, 12);
					h = $urandom_range(0, 12);
					b = $urandom_range(0, 6);
					ew = (w == 0) ? 1 : w;
					eh = (h == 0) ? 1 : h;
					frame = ew * eh;
					n = $urandom_range(1, 3) * frame + $urandom_range(0, frame - 1);
				end
			endcase
			if (n > 300) n = 300;
			configure(w, h, b);
			repeat (n) push_sample(random_sample());
			drain();
			phase++;
		end

		if (errors == 0) begin
			$display("PASS mask_box_downsample");
		end else begin
			$display("FAIL mask_box_downsample");
		end
		$finish;
	end

	// Hard stop on a hung handshake
	initial begin
		#10ms;
		$display("FAIL mask_box_downsample");
		$finish;
	end

endmodule

// File: mask_box_downsample.f
hw/rtl/mbd_pkg.sv
hw/rtl/mbd_ctrl.sv
hw/rtl/mbd_dp.sv
hw/rtl/mask_box_downsample.sv
hw/rtl/mbd_chk.sv
tb/sv/tb_mask_box_downsample.sv
